[src/dtps_pkg.sv]
// Shared constants and types for the drive telemetry poll sequencer.
package dtps_pkg;

  localparam int unsigned WordW    = 16;
  localparam int unsigned PressW   = 11;
  localparam int unsigned CountW   = 3;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 128;
  localparam int unsigned CfgAddrW = 5;

  // Decode thresholds for voltage words and pressures, all in raw register units.
  localparam logic [WordW-1:0] BusLow    = 16'd1500;
  localparam logic [WordW-1:0] BusHigh   = 16'd9000;
  localparam logic [WordW-1:0] NearFreq  = 16'd200;
  localparam logic [WordW-1:0] SmallVout = 16'd500;
  localparam logic [WordW-1:0] PressMax  = 16'd2000;

  localparam logic [CountW-1:0] CountBlock  = 3'd4;
  localparam logic [CountW-1:0] CountSingle = 3'd1;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegEnable   = 3'd0;
  localparam logic [2:0] RegPeriod   = 3'd1;
  localparam logic [2:0] RegAddrBlk  = 3'd2;
  localparam logic [2:0] RegAddrStat = 3'd3;
  localparam logic [2:0] RegAddrPfb  = 3'd4;
  localparam logic [2:0] RegAddrPset = 3'd5;

  typedef struct packed {
    logic [WordW-1:0] vdc;
    logic [WordW-1:0] vout;
  } dtps_volt_t;

endpackage

[src/dtps_volt_decode.sv]
// Tells the DC bus word apart from the output voltage word of a block read.
module dtps_volt_decode (
  input  logic [dtps_pkg::WordW-1:0] freq_word,
  input  logic [dtps_pkg::WordW-1:0] word1,
  input  logic [dtps_pkg::WordW-1:0] word2,
  output dtps_pkg::dtps_volt_t       volt
);
  import dtps_pkg::*;

  logic             bus1;
  logic             bus2;
  logic             mirror1;
  logic             at1;
  logic [WordW-1:0] diff1;
  logic [WordW-1:0] scaled1;
  logic [WordW-1:0] scaled2;
  logic [WordW-1:0] onevolt2;

  assign bus1    = (word1 >= BusLow) && (word1 <= BusHigh);
  assign bus2    = (word2 >= BusLow) && (word2 <= BusHigh);
  assign diff1   = (word1 >= freq_word) ? (word1 - freq_word) : (freq_word - word1);
  // A word close to a nonzero frequency is the frequency mirrored.
  assign mirror1 = (freq_word != '0) && (diff1 <= NearFreq);
  assign at1     = bus1 && !mirror1;

  // Below 500 the product is at most 4990, so 16 bits hold it.
  assign scaled1  = WordW'(word1 * 4'd10);
  assign scaled2  = WordW'(word2 * 4'd10);
  assign onevolt2 = (word2 < SmallVout) ? scaled2 : word2;

  always_comb begin
    if (bus2 && !at1) begin
      volt.vdc  = word2;
      volt.vout = (!mirror1 && (word1 != '0) && (word1 < SmallVout)) ? scaled1 : '0;
    end else if (at1) begin
      volt.vdc  = word1;
      volt.vout = bus2 ? '0 : onevolt2;
    end else begin
      volt.vdc  = word1;
      volt.vout = onevolt2;
    end
  end

endmodule

[src/drive_telemetry_poll_sequencer_core.sv]
// Top level of the drive telemetry poll sequencer: input stage, poll sequencer, output stage.
// An accepted word is registered in the input stage; the sequencer step works on it there and
// registers its result word in the output stage, which drives out_tdata.
// Throughput: one word per cycle while the skid entry is free. A two-entry output stage holds
// one result behind a stalled head word; then the input stalls until the head is taken.
// Reset (rst_n low, synchronous): phase idle, nothing outstanding, due time and all stored
// telemetry zero, configuration registers to their defaults, both stages empty.
module drive_telemetry_poll_sequencer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input words.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] now_ms, [32] cli_idle, [33] bus_busy, [34] result_ok, [50:35] word0,
  // [66:51] word1, [82:67] word2, [98:83] word3, [99] request_ready, [103:100] zero
  input  logic [dtps_pkg::InDataW-1:0]       in_tdata,
  // Result words.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] req_valid, [16:1] req_addr, [19:17] req_count, [20] report_valid,
  // [36:21] freq_centihz, [52:37] current_centiamp, [68:53] vdc_tenths,
  // [84:69] vout_tenths, [95:85] pset_tenths, [106:96] pfb_tenths,
  // [122:107] drive_status, [127:123] zero
  output logic [dtps_pkg::OutDataW-1:0]      out_tdata,
  // Configuration port.
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [dtps_pkg::CfgAddrW-1:0]      cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import dtps_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BLOCK,
    PH_STATUS,
    PH_PFB,
    PH_PSET
  } phase_t;

  // Configuration registers.
  logic             enable_r;
  logic [WordW-1:0] period_r;
  logic [WordW-1:0] addr_blk_r;
  logic [WordW-1:0] addr_stat_r;
  logic [WordW-1:0] addr_pfb_r;
  logic [WordW-1:0] addr_pset_r;

  // Sequencer state and stored telemetry.
  phase_t            phase_r, phase_nxt;
  logic              await_r, await_nxt;
  logic [31:0]       due_r, due_nxt;
  logic [WordW-1:0]  freq_r, freq_nxt;
  logic [WordW-1:0]  cur_r, cur_nxt;
  logic [WordW-1:0]  vdc_r, vdc_nxt;
  logic [WordW-1:0]  vout_r, vout_nxt;
  logic [PressW-1:0] pset_r, pset_nxt;
  logic [PressW-1:0] pfb_r, pfb_nxt;
  logic [WordW-1:0]  stat_r, stat_nxt;

  // Input stage and two-entry output stage.
  logic                in_valid_r;
  logic [InDataW-1:0]  in_data_r;
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic                skid_valid_r;
  logic [OutDataW-1:0] skid_data_r;

  logic cfg_wr;
  logic fire;
  logic out_pop;

  // Fields of the word in the input stage.
  logic [31:0]      now_ms;
  logic             cli_idle;
  logic             bus_busy;
  logic             result_ok;
  logic [WordW-1:0] word0;
  logic [WordW-1:0] word1;
  logic [WordW-1:0] word2;
  logic [WordW-1:0] word3;
  logic             request_ready;

  // Result of this step.
  logic             req_valid;
  logic [WordW-1:0] req_addr;
  logic [CountW-1:0] req_count;
  logic             report_valid;
  logic             finish;
  logic             due;
  logic [31:0]      elapsed;
  logic [OutDataW-1:0] res_data;
  dtps_volt_t       volt;

  assign now_ms        = in_data_r[31:0];
  assign cli_idle      = in_data_r[32];
  assign bus_busy      = in_data_r[33];
  assign result_ok     = in_data_r[34];
  assign word0         = in_data_r[50:35];
  assign word1         = in_data_r[66:51];
  assign word2         = in_data_r[82:67];
  assign word3         = in_data_r[98:83];
  assign request_ready = in_data_r[99];

  dtps_volt_decode u_volt (
    .freq_word (word0),
    .word1     (word1),
    .word2     (word2),
    .volt      (volt)
  );

  // The sequencer steps whenever the input stage holds a word and the skid entry is
  // free, so the new result always has a place even if the head word stalls.
  assign fire      = in_valid_r && !skid_valid_r;
  assign in_tready = !in_valid_r || fire;
  assign out_pop   = out_valid_r && out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration access: writes land at the access phase, reads are direct.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[4:2])
      RegEnable:   cfg_prdata = {31'd0, enable_r};
      RegPeriod:   cfg_prdata = {16'd0, period_r};
      RegAddrBlk:  cfg_prdata = {16'd0, addr_blk_r};
      RegAddrStat: cfg_prdata = {16'd0, addr_stat_r};
      RegAddrPfb:  cfg_prdata = {16'd0, addr_pfb_r};
      RegAddrPset: cfg_prdata = {16'd0, addr_pset_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // The due test is wrap-aware: the cycle is due once now_ms is at or past the
  // scheduled time within half the 32-bit range.
  assign elapsed = now_ms - due_r;
  assign due     = !elapsed[31];

  // One poll tick. The idle phase may start a block read; every other phase
  // consumes the outstanding read once the bus is free and issues the next one or ends the cycle.
  always_comb begin
    phase_nxt    = phase_r;
    await_nxt    = await_r;
    due_nxt      = due_r;
    freq_nxt     = freq_r;
    cur_nxt      = cur_r;
    vdc_nxt      = vdc_r;
    vout_nxt     = vout_r;
    pset_nxt     = pset_r;
    pfb_nxt      = pfb_r;
    stat_nxt     = stat_r;
    req_valid    = 1'b0;
    req_addr     = '0;
    req_count    = '0;
    report_valid = 1'b0;
    finish       = 1'b0;

    if (enable_r) begin
      if (phase_r == PH_IDLE) begin
        if (cli_idle && due && !bus_busy && request_ready) begin
          req_valid = 1'b1;
          req_addr  = addr_blk_r;
          req_count = CountBlock;
          phase_nxt = PH_BLOCK;
          await_nxt = 1'b1;
        end
      end else if (!bus_busy && await_r) begin
        await_nxt = 1'b0;
        case (phase_r)
          PH_BLOCK: begin
            if (result_ok) begin
              freq_nxt = word0;
              cur_nxt  = word3;
              vdc_nxt  = volt.vdc;
              vout_nxt = volt.vout;
            end
            // A refused status request ends the cycle without a report.
            if (request_ready) begin
              req_valid = 1'b1;
              req_addr  = addr_stat_r;
              req_count = CountSingle;
              phase_nxt = PH_STATUS;
              await_nxt = 1'b1;
            end else begin
              finish = 1'b1;
            end
          end
          PH_STATUS: begin
            if (result_ok) begin
              stat_nxt = word0;
            end
            if (request_ready) begin
              req_valid = 1'b1;
              req_addr  = addr_pfb_r;
              req_count = CountSingle;
              phase_nxt = PH_PFB;
              await_nxt = 1'b1;
            end else begin
              report_valid = 1'b1;
              finish       = 1'b1;
            end
          end
          PH_PFB: begin
            // An out-of-range feedback pressure is stored as zero.
            if (result_ok) begin
              pfb_nxt = (word0 <= PressMax) ? word0[PressW-1:0] : '0;
            end
            if (request_ready) begin
              req_valid = 1'b1;
              req_addr  = addr_pset_r;
              req_count = CountSingle;
              phase_nxt = PH_PSET;
              await_nxt = 1'b1;
            end else begin
              report_valid = 1'b1;
              finish       = 1'b1;
            end
          end
          PH_PSET: begin
            // An out-of-range setpoint leaves the previous one in place.
            if (result_ok && (word0 <= PressMax)) begin
              pset_nxt = word0[PressW-1:0];
            end
            report_valid = 1'b1;
            finish       = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end

    if (finish) begin
      phase_nxt = PH_IDLE;
      due_nxt   = now_ms + {16'd0, period_r};
    end
  end

  // Report fields read the values stored by this very tick, zero without a report.
  always_comb begin
    res_data = '0;
    res_data[0]     = req_valid;
    res_data[16:1]  = req_addr;
    res_data[19:17] = req_count;
    res_data[20]    = report_valid;
    if (report_valid) begin
      res_data[36:21]   = freq_nxt;
      res_data[52:37]   = cur_nxt;
      res_data[68:53]   = vdc_nxt;
      res_data[84:69]   = vout_nxt;
      res_data[95:85]   = pset_nxt;
      res_data[106:96]  = pfb_nxt;
      res_data[122:107] = stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      period_r     <= 16'd1000;
      addr_blk_r   <= 16'd4097;
      addr_stat_r  <= 16'd0;
      addr_pfb_r   <= 16'd4112;
      addr_pset_r  <= 16'd0;
      phase_r      <= PH_IDLE;
      await_r      <= 1'b0;
      due_r        <= '0;
      freq_r       <= '0;
      cur_r        <= '0;
      vdc_r        <= '0;
      vout_r       <= '0;
      pset_r       <= '0;
      pfb_r        <= '0;
      stat_r       <= '0;
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          RegEnable:   enable_r    <= cfg_pwdata[0];
          RegPeriod:   period_r    <= cfg_pwdata[15:0];
          RegAddrBlk:  addr_blk_r  <= cfg_pwdata[15:0];
          RegAddrStat: addr_stat_r <= cfg_pwdata[15:0];
          RegAddrPfb:  addr_pfb_r  <= cfg_pwdata[15:0];
          RegAddrPset: addr_pset_r <= cfg_pwdata[15:0];
          default: begin
          end
        endcase
      end

      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end

      if (fire) begin
        phase_r <= phase_nxt;
        await_r <= await_nxt;
        due_r   <= due_nxt;
        freq_r  <= freq_nxt;
        cur_r   <= cur_nxt;
        vdc_r   <= vdc_nxt;
        vout_r  <= vout_nxt;
        pset_r  <= pset_nxt;
        pfb_r   <= pfb_nxt;
        stat_r  <= stat_nxt;
      end

      // Output stage: the head word holds until taken; a new result that finds
      // the head stalled waits in the skid entry.
      if (fire) begin
        if (!out_valid_r || out_pop) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_r  <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
    end
    if (fire) begin
      if (!out_valid_r || out_pop) begin
        out_data_r <= res_data;
      end else begin
        skid_data_r <= res_data;
      end
    end else if (out_pop && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

  // The skid entry only fills behind a stalled head word.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a word while the head is empty");

  // A read is outstanding only outside the idle phase.
  a_await_phase: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (phase_r != PH_IDLE))
    else $error("read outstanding in idle phase");

  // A report never comes out of the idle phase.
  a_no_idle_report: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (phase_r == PH_IDLE)) |-> !report_valid)
    else $error("report issued from idle phase");

  // While disabled a tick leaves the sequencer untouched.
  a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !enable_r) |=> ($stable(phase_r) && $stable(due_r)))
    else $error("sequencer moved while disabled");

  // A block read request always asks for four words and a single read for one.
  a_req_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && req_valid) |-> ((phase_r == PH_IDLE) == (req_count == CountBlock)))
    else $error("request word count does not match phase");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the drive telemetry poll sequencer core.
module testbench;
  import dtps_pkg::*;

  // Input word layout, first field in the lowest bits (matches in_tdata).
  typedef struct packed {
    logic [3:0]       pad;
    logic             request_ready;
    logic [WordW-1:0] word3;
    logic [WordW-1:0] word2;
    logic [WordW-1:0] word1;
    logic [WordW-1:0] word0;
    logic             result_ok;
    logic             bus_busy;
    logic             cli_idle;
    logic [31:0]      now_ms;
  } poll_tick_t;

  // Result word layout, first field in the lowest bits (matches out_tdata).
  typedef struct packed {
    logic [4:0]        pad;
    logic [WordW-1:0]  drive_status;
    logic [PressW-1:0] pfb_tenths;
    logic [PressW-1:0] pset_tenths;
    logic [WordW-1:0]  vout_tenths;
    logic [WordW-1:0]  vdc_tenths;
    logic [WordW-1:0]  current_centiamp;
    logic [WordW-1:0]  freq_centihz;
    logic              report_valid;
    logic [CountW-1:0] req_count;
    logic [WordW-1:0]  req_addr;
    logic              req_valid;
  } poll_result_t;

  // Steps of one poll cycle: idle, then one step per outstanding read.
  typedef enum logic [2:0] {
    PollIdle, PollBlock, PollStatus, PollPfb, PollPset
  } poll_phase_t;

  // Run ends when this many cycles pass without any word moving on either side.
  localparam int unsigned QuietLimit = 2000;

  // The scoreboard keeps its own copy of the sequencer state and registers, works out
  // the result word of every accepted tick and checks results in order.
  class telemetry_scoreboard;
    bit               enable;
    logic [WordW-1:0] period_ms, addr_block, addr_status, addr_pfb, addr_pset;
    poll_phase_t      phase;
    bit               awaiting;
    logic [31:0]      next_due_ms;
    logic [WordW-1:0] freq, current, vdc, vout, status;
    logic [PressW-1:0] pset, pfb;
    poll_result_t     expected_words[$];
    int unsigned      errors;

    function new();
      enable      = 1'b0;
      period_ms   = 16'd1000;
      addr_block  = 16'd4097;
      addr_status = 16'd0;
      addr_pfb    = 16'd4112;
      addr_pset   = 16'd0;
      phase       = PollIdle;
      awaiting    = 1'b0;
      next_due_ms = '0;
      freq = '0; current = '0; vdc = '0; vout = '0; status = '0;
      pset = '0; pfb = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        RegEnable:   enable      = value[0];
        RegPeriod:   period_ms   = value[15:0];
        RegAddrBlk:  addr_block  = value[15:0];
        RegAddrStat: addr_status = value[15:0];
        RegAddrPfb:  addr_pfb    = value[15:0];
        RegAddrPset: addr_pset   = value[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        RegEnable:   return {31'd0, enable};
        RegPeriod:   return {16'd0, period_ms};
        RegAddrBlk:  return {16'd0, addr_block};
        RegAddrStat: return {16'd0, addr_status};
        RegAddrPfb:  return {16'd0, addr_pfb};
        RegAddrPset: return {16'd0, addr_pset};
        default:     return '0;
      endcase
    endfunction

    function bit bus_like(logic [WordW-1:0] w);
      return w >= BusLow && w <= BusHigh;
    endfunction

    // A word that sits close to a nonzero frequency word is taken as a frequency mirror.
    function bit mirrors(logic [WordW-1:0] w, logic [WordW-1:0] f);
      logic [WordW-1:0] d;
      if (f == '0) return 1'b0;
      d = (w >= f) ? w - f : f - w;
      return d <= NearFreq;
    endfunction

    function logic [WordW-1:0] volt_scale(logic [WordW-1:0] w);
      return (w < SmallVout) ? w * 16'd10 : w;
    endfunction

    function void decode_block(logic [WordW-1:0] f, logic [WordW-1:0] w1,
                               logic [WordW-1:0] w2, logic [WordW-1:0] cur);
      bit at2, at1;
      at2 = bus_like(w2);
      at1 = bus_like(w1) && !mirrors(w1, f);
      freq = f;
      current = cur;
      if (at2 && !at1) begin
        vdc  = w2;
        vout = (!mirrors(w1, f) && w1 > 0 && w1 < SmallVout) ? w1 * 16'd10 : '0;
      end else if (at1) begin
        vdc  = w1;
        vout = at2 ? '0 : volt_scale(w2);
      end else begin
        vdc  = w1;
        vout = volt_scale(w2);
      end
    endfunction

    function void take_tick(poll_tick_t t);
      poll_result_t     r;
      logic [31:0]      since;
      bit               finish, last, partial;
      poll_phase_t      next_ph;
      logic [WordW-1:0] next_addr;
      r = '0;
      finish = 1'b0;
      last = 1'b0;
      partial = 1'b0;
      next_ph = PollIdle;
      next_addr = '0;
      if (enable) begin
        if (phase == PollIdle) begin
          // Wrap-aware due test: the cycle is due once now is not behind the due time.
          since = t.now_ms - next_due_ms;
          if (t.cli_idle && !since[31] && !t.bus_busy && t.request_ready) begin
            r.req_valid = 1'b1;
            r.req_addr  = addr_block;
            r.req_count = CountBlock;
            phase = PollBlock;
            awaiting = 1'b1;
          end
        end else if (!t.bus_busy && awaiting) begin
          awaiting = 1'b0;
          case (phase)
            PollBlock: begin
              if (t.result_ok) decode_block(t.word0, t.word1, t.word2, t.word3);
              next_ph = PollStatus;
              next_addr = addr_status;
            end
            PollStatus: begin
              if (t.result_ok) status = t.word0;
              next_ph = PollPfb;
              next_addr = addr_pfb;
              partial = 1'b1;
            end
            PollPfb: begin
              if (t.result_ok) pfb = (t.word0 <= PressMax) ? t.word0[PressW-1:0] : '0;
              next_ph = PollPset;
              next_addr = addr_pset;
              partial = 1'b1;
            end
            default: begin
              // An out-of-range setpoint leaves the previous one in place.
              if (t.result_ok && t.word0 <= PressMax) pset = t.word0[PressW-1:0];
              last = 1'b1;
            end
          endcase
          if (!last && t.request_ready) begin
            r.req_valid = 1'b1;
            r.req_addr  = next_addr;
            r.req_count = CountSingle;
            phase = next_ph;
            awaiting = 1'b1;
          end else begin
            // A refused status request ends the cycle quietly; later steps still report.
            finish = 1'b1;
            r.report_valid = last || partial;
          end
        end
      end
      if (finish) begin
        phase = PollIdle;
        next_due_ms = t.now_ms + {16'd0, period_ms};
      end
      if (r.report_valid) begin
        r.freq_centihz     = freq;
        r.current_centiamp = current;
        r.vdc_tenths       = vdc;
        r.vout_tenths      = vout;
        r.pset_tenths      = pset;
        r.pfb_tenths       = pfb;
        r.drive_status     = status;
      end
      expected_words.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task check_result(poll_result_t got);
      poll_result_t want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result word 0x%0h", got));
      end else begin
        want = expected_words.pop_front();
        compare_field("req_valid", got.req_valid, want.req_valid);
        compare_field("req_addr", got.req_addr, want.req_addr);
        compare_field("req_count", got.req_count, want.req_count);
        compare_field("report_valid", got.report_valid, want.report_valid);
        compare_field("freq_centihz", got.freq_centihz, want.freq_centihz);
        compare_field("current_centiamp", got.current_centiamp, want.current_centiamp);
        compare_field("vdc_tenths", got.vdc_tenths, want.vdc_tenths);
        compare_field("vout_tenths", got.vout_tenths, want.vout_tenths);
        compare_field("pset_tenths", got.pset_tenths, want.pset_tenths);
        compare_field("pfb_tenths", got.pfb_tenths, want.pfb_tenths);
        compare_field("drive_status", got.drive_status, want.drive_status);
      end
    endtask

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  telemetry_scoreboard sb = new();

  // Idle rates in percent for the sender and the receiver, and a receiver hold-off
  // that the receiver process counts down itself.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold;
  int unsigned quiet_cycles;

  // Millisecond clock seen by the poll ticks, and the largest step between two ticks.
  logic [31:0] clock_ms;
  int unsigned max_step;

  drive_telemetry_poll_sequencer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready changes on the falling edge. A pending hold-off wins over the
  // random idling, so the core's output stage fills and it stops taking words.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold > 0) begin
        out_tready <= 1'b0;
        recv_hold--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor on the rising edge: every accepted tick goes to the predictor, every
  // accepted result is checked. The same block runs the watchdog on silent cycles.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.take_tick(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic poll_tick_t mk(logic [31:0] now, bit idle, bit busy, bit ok,
                                    logic [15:0] w0, logic [15:0] w1, logic [15:0] w2,
                                    logic [15:0] w3, bit ready);
    poll_tick_t t;
    t = '0;
    t.now_ms = now;
    t.cli_idle = idle;
    t.bus_busy = busy;
    t.result_ok = ok;
    t.word0 = w0;
    t.word1 = w1;
    t.word2 = w2;
    t.word3 = w3;
    t.request_ready = ready;
    return t;
  endfunction

  // Voltage words are drawn from the classes the decoder tells apart: bus-like,
  // close to the frequency word, 1 V scale, zero, the class boundaries, anything.
  function automatic logic [15:0] volt_word(logic [15:0] f);
    int near;
    case ($urandom_range(5))
      0: return 16'($urandom_range(1500, 9000));
      1: begin
        near = int'(f) + int'($urandom_range(0, 400)) - 200;
        if (near < 0) near = 0;
        if (near > 65535) near = 65535;
        return 16'(near);
      end
      2: return 16'($urandom_range(0, 499));
      3: return 16'd0;
      4: begin
        case ($urandom_range(5))
          0: return 16'd1499;
          1: return 16'd1500;
          2: return 16'd9000;
          3: return 16'd9001;
          4: return 16'd499;
          default: return 16'd500;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Random tick shaped after the step the sequencer waits in, so that most cycles run
  // to the end; busy bus, refused requests and failed reads break some of them.
  function automatic poll_tick_t random_tick();
    poll_tick_t t;
    int unsigned pick;
    t = '0;
    if ($urandom_range(39) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, max_step);
    t.now_ms = clock_ms;
    t.cli_idle = ($urandom_range(99) < 85);
    t.bus_busy = ($urandom_range(99) < 20);
    t.result_ok = ($urandom_range(99) < 85);
    t.request_ready = ($urandom_range(99) < 85);
    pick = $urandom_range(9);
    if (sb.phase == PollPfb || sb.phase == PollPset) begin
      case (pick)
        0: t.word0 = PressMax;
        1: t.word0 = PressMax + 16'd1;
        2, 3: t.word0 = 16'($urandom);
        default: t.word0 = 16'($urandom_range(0, 2000));
      endcase
    end else begin
      case (pick)
        0: t.word0 = 16'd0;
        1, 2: t.word0 = 16'($urandom);
        default: t.word0 = 16'($urandom_range(1, 6000));
      endcase
    end
    t.word1 = volt_word(t.word0);
    t.word2 = volt_word(t.word0);
    t.word3 = 16'($urandom);
    return t;
  endfunction

  // Offer one tick and wait until it is taken. A fresh tick is drawn only at the
  // falling edge, after the previous one has reached the predictor.
  task automatic send_tick(input poll_tick_t t, input bit fresh);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    if (fresh) t = random_tick();
    in_tvalid <= 1'b1;
    in_tdata <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) send_tick('0, 1'b1);
  endtask

  // Stop offering and wait until every predicted result word has been checked,
  // then let the pipeline settle for as long as the settle argument asks.
  task automatic drain(int unsigned settle);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write a register with a setup and an access phase, then read it back the same way.
  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== sb.reg_value(idx))
      sb.report_mismatch($sformatf("register %0d reads 0x%0h, want 0x%0h",
                                   idx, readback, sb.reg_value(idx)));
  endtask

  task automatic configure(logic [15:0] period, logic [15:0] blk, logic [15:0] stat,
                           logic [15:0] pfb, logic [15:0] pset);
    apb_write(RegPeriod, {16'd0, period});
    apb_write(RegAddrBlk, {16'd0, blk});
    apb_write(RegAddrStat, {16'd0, stat});
    apb_write(RegAddrPfb, {16'd0, pfb});
    apb_write(RegAddrPset, {16'd0, pset});
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    quiet_cycles = 0;
    recv_hold = 0;
    clock_ms = '0;
    max_step = 0;
    // First idling mode: the sender idles in a third of the cycles, the receiver in
    // two thirds.
    send_idle_pct = 33;
    recv_idle_pct = 68;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Out of reset the block is disabled: ticks that would start a cycle do nothing.
    send_tick(mk(32'd0, 1, 0, 1, 16'd0, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    send_tick(mk(32'd5000, 1, 0, 1, 16'd0, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    drain(4);
    apb_write(RegEnable, 32'd1);
    configure(16'd10, 16'hFFFF, 16'h0000, 16'h1234, 16'h8001);

    // Directed cycles. The command interface busy, the bus busy and a refused block
    // request all hold the start back.
    send_tick(mk(32'd0, 0, 0, 1, 16'd0, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    send_tick(mk(32'd0, 1, 1, 1, 16'd0, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    send_tick(mk(32'd0, 1, 0, 1, 16'd0, 16'd0, 16'd0, 16'd0, 0), 1'b0);
    send_tick(mk(32'd1, 1, 0, 1, 16'd0, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    // Bus still busy while a read is outstanding: nothing happens.
    send_tick(mk(32'd2, 1, 1, 1, 16'd0, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    // Bus-like third word, second word mirroring the frequency.
    send_tick(mk(32'd3, 1, 0, 1, 16'd1000, 16'd1100, 16'd3000, 16'd250, 1), 1'b0);
    send_tick(mk(32'd4, 0, 0, 1, 16'd3, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    // Feedback pressure above range is stored as zero.
    send_tick(mk(32'd5, 1, 0, 1, 16'd2001, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    send_tick(mk(32'd6, 1, 0, 1, 16'd2000, 16'd0, 16'd0, 16'd0, 0), 1'b0);
    // Not yet due, then due exactly one period after the report.
    send_tick(mk(32'd10, 1, 0, 1, 16'd0, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    send_tick(mk(32'd16, 1, 0, 1, 16'd0, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    // Failed block read keeps the values; refused status request ends without report.
    send_tick(mk(32'd17, 1, 0, 0, 16'd5000, 16'd5000, 16'd5000, 16'd5000, 0), 1'b0);
    send_tick(mk(32'd27, 1, 0, 1, 16'd0, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    // Zero frequency, both voltage words bus-like.
    send_tick(mk(32'd28, 1, 0, 1, 16'd0, 16'd5000, 16'd4000, 16'd100, 1), 1'b0);
    // Refused pressure request after the status read still reports.
    send_tick(mk(32'd29, 1, 0, 1, 16'd1, 16'd0, 16'd0, 16'd0, 0), 1'b0);
    send_tick(mk(32'd39, 1, 0, 1, 16'd0, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    // Neither voltage word bus-like, largest values in the other words.
    send_tick(mk(32'd40, 1, 0, 1, 16'hFFFF, 16'd400, 16'hFFFF, 16'hFFFF, 1), 1'b0);
    send_tick(mk(32'd41, 1, 0, 1, 16'd2, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    send_tick(mk(32'd42, 1, 0, 1, 16'd2000, 16'd0, 16'd0, 16'd0, 0), 1'b0);
    send_tick(mk(32'd52, 1, 0, 1, 16'd0, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    // A 1 V-scale output voltage at its top end is stored times ten.
    send_tick(mk(32'd53, 1, 0, 1, 16'd6000, 16'd499, 16'd1500, 16'd0, 1), 1'b0);
    send_tick(mk(32'd54, 1, 0, 0, 16'd7, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    send_tick(mk(32'd55, 1, 0, 1, 16'd1999, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    // Setpoint above range keeps the previous setpoint.
    send_tick(mk(32'd56, 1, 0, 1, 16'd2001, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    // Just before the wrap the due time lies ahead, so nothing starts.
    send_tick(mk(32'hFFFF_FFF0, 1, 0, 1, 16'd0, 16'd0, 16'd0, 16'd0, 1), 1'b0);
    drain(4);

    // Zero period, clock running across the wrap.
    configure(16'd0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    clock_ms = 32'hFFFF_FF80;
    max_step = 40;
    run_random(180);
    drain(4);

    // Longest period with large time steps; idling rates swapped.
    send_idle_pct = 68;
    recv_idle_pct = 33;
    configure(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    max_step = 30000;
    run_random(180);
    drain(4);

    // No idling on either side. Midway the receiver holds off long enough for the
    // core to stall its input, and later the sender waits for every result.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(16'($urandom_range(1, 200)), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
    max_step = 100;
    run_random(60);
    recv_hold = 40;
    run_random(60);
    drain(0);
    run_random(60);
    drain(4);

    // Disabled again: the state is held while ticks arrive.
    apb_write(RegEnable, 32'd0);
    run_random(20);
    drain(4);

    apb_write(RegEnable, 32'd1);
    configure(16'd1000, 16'd4097, 16'd0, 16'd4112, 16'd0);
    max_step = 600;
    run_random(40);
    drain(6);

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
src/dtps_pkg.sv
src/dtps_volt_decode.sv
src/drive_telemetry_poll_sequencer_core.sv
tb/sv/testbench.sv
